// ===== sv/hgnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgnp_pkg
// Shared widths, codes and reset values for the heading-gated nearest point
// search.
// ----------------------------------------------------------------------------
package hgnp_pkg;

  // field widths
  localparam int REQ_W   = 2;
  localparam int COORD_W = 24;
  localparam int HDG_W   = 16;
  localparam int IDX_W   = 8;

  // default store depth
  localparam int MAX_POINTS_DEF = 256;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // heading gate after reset: sixty degrees at 65536 per turn
  localparam logic [HDG_W-1:0] GATE_RESET = 16'd10923;

  // distance arithmetic widths
  localparam int DIFF_W = COORD_W + 1;      // coordinate difference
  localparam int SQ_W   = 2 * COORD_W + 1;  // one squared difference
  localparam int D2_W   = SQ_W + 1;         // sum of two squares

endpackage

// ===== sv/hgnp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgnp_req_if / hgnp_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface hgnp_req_if;
  logic                                valid;
  logic                                ready;
  logic [hgnp_pkg::REQ_W-1:0]          req_type;
  logic signed [hgnp_pkg::COORD_W-1:0] pos_x;
  logic signed [hgnp_pkg::COORD_W-1:0] pos_y;
  logic [hgnp_pkg::HDG_W-1:0]          heading;

  modport source (output valid, req_type, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, heading, output ready);
endinterface

interface hgnp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [hgnp_pkg::IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

// ===== sv/heading_gated_nearest_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_gated_nearest_point
// Path point store with a heading-gated nearest point search.
// ----------------------------------------------------------------------------
// Channels: req (sink) takes request words: clear, load one point, or query
// with the vehicle pose. rsp (source) returns one word per query: found and
// the index of the nearest point whose heading lies within the gate; the
// lowest index wins a tie. cfg_we/cfg_wdata write the heading gate.
// Clear and load complete without leaving idle; a load into a full store is dropped.
// For a query, the scan reads one stored point per cycle from the point
// memory through a four-stage distance and compare pipeline; once the
// pipeline drains, the result enters the output register.
// req.ready is high only while no query is in progress.
// A finished result sits in the output register; a stalled receiver does not
// block clears, loads or the next query's scan. A query finishing while the
// previous result is still unclaimed waits for it to be taken.
// Reset empties the store and sets the gate to sixty degrees. The point
// memory is not cleared; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module heading_gated_nearest_point #(
  parameter int MAX_POINTS = hgnp_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hgnp_pkg::HDG_W-1:0] cfg_wdata,
  hgnp_req_if.sink                   req,
  hgnp_rsp_if.source                 rsp
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CRD_W = hgnp_pkg::COORD_W;
  localparam int HW = hgnp_pkg::HDG_W;
  localparam int MW = 2 * CRD_W + HW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // configuration and store control
  logic [HW-1:0] heading_gate;
  logic [CW-1:0] point_count;
  logic [CW-1:0] issue_cnt;

  // query pose
  logic [CRD_W-1:0] q_x;
  logic [CRD_W-1:0] q_y;
  logic [HW-1:0]    q_hdg;

  // point memory: {x, y, heading}
  logic [MW-1:0] point_mem [MAX_POINTS];
  logic [MW-1:0] rd_data;
  logic          mem_we;
  logic          rd_en;

  // pipeline
  logic                                 rd_valid;
  logic [AW-1:0]                        rd_idx;
  logic                                 s1_valid;
  logic [AW-1:0]                        s1_idx;
  logic signed [hgnp_pkg::DIFF_W-1:0]   s1_dx;
  logic signed [hgnp_pkg::DIFF_W-1:0]   s1_dy;
  logic                                 s2_valid;
  logic [AW-1:0]                        s2_idx;
  logic [hgnp_pkg::SQ_W-1:0]            s2_sqx;
  logic [hgnp_pkg::SQ_W-1:0]            s2_sqy;
  logic                                 s3_valid;
  logic [AW-1:0]                        s3_idx;
  logic [hgnp_pkg::D2_W-1:0]            s3_d2;

  // running best
  logic                      have;
  logic [AW-1:0]             best_idx;
  logic [hgnp_pkg::D2_W-1:0] best_d2;

  // output register
  logic                       rsp_valid;
  logic                       rsp_found;
  logic [hgnp_pkg::IDX_W-1:0] rsp_index;

  logic accept;
  logic pipe_busy;
  logic out_free;

  // stage-one and stage-two combinational terms
  logic [CRD_W-1:0]                   pt_x;
  logic [CRD_W-1:0]                   pt_y;
  logic [HW-1:0]                      pt_hdg;
  logic [HW-1:0]                      hdg_diff;
  logic [HW:0]                        hdg_mag;
  logic                               hdg_pass;
  logic signed [2*hgnp_pkg::DIFF_W-1:0] prod_x;
  logic signed [2*hgnp_pkg::DIFF_W-1:0] prod_y;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign pipe_busy = rd_valid || s1_valid || s2_valid || s3_valid;
  assign out_free  = !rsp_valid || rsp.ready;
  assign mem_we    = accept && (req.req_type == hgnp_pkg::REQ_LOAD) &&
                     (point_count < CW'(MAX_POINTS));
  assign rd_en     = (state == ST_SCAN) && (issue_cnt < point_count);

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.match_index = rsp_index;

  // heading gate register
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_gate <= hgnp_pkg::GATE_RESET;
    end else if (cfg_we) begin
      heading_gate <= cfg_wdata;
    end
  end

  // point memory; loads only happen while idle, so no read can overlap them
  always_ff @(posedge clk) begin
    if (mem_we) begin
      point_mem[point_count[AW-1:0]] <= {req.pos_x, req.pos_y, req.heading};
    end
    if (rd_en) begin
      rd_data <= point_mem[issue_cnt[AW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      issue_cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              hgnp_pkg::REQ_CLEAR: point_count <= '0;
              hgnp_pkg::REQ_LOAD: begin
                if (mem_we) begin
                  point_count <= point_count + CW'(1);
                end
              end
              hgnp_pkg::REQ_QUERY: begin
                issue_cnt <= '0;
                state     <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end else if (!pipe_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query pose capture
  always_ff @(posedge clk) begin
    if (accept && (req.req_type == hgnp_pkg::REQ_QUERY)) begin
      q_x   <= req.pos_x;
      q_y   <= req.pos_y;
      q_hdg <= req.heading;
    end
  end

  // stage one: heading gate and coordinate differences
  always_comb begin
    {pt_x, pt_y, pt_hdg} = rd_data;
    hdg_diff = q_hdg - pt_hdg;
    if (hdg_diff[HW-1]) begin
      hdg_mag = {1'b1, {HW{1'b0}}} - {1'b0, hdg_diff};
    end else begin
      hdg_mag = {1'b0, hdg_diff};
    end
    hdg_pass = (hdg_mag <= {1'b0, heading_gate});
  end

  // stage two: squares
  assign prod_x = s1_dx * s1_dx;
  assign prod_y = s1_dy * s1_dy;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      s1_valid <= rd_valid && hdg_pass;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[AW-1:0];
    s1_idx <= rd_idx;
    s1_dx  <= {q_x[CRD_W-1], q_x} - {pt_x[CRD_W-1], pt_x};
    s1_dy  <= {q_y[CRD_W-1], q_y} - {pt_y[CRD_W-1], pt_y};
    s2_idx <= s1_idx;
    s2_sqx <= prod_x[hgnp_pkg::SQ_W-1:0];
    s2_sqy <= prod_y[hgnp_pkg::SQ_W-1:0];
    s3_idx <= s2_idx;
    s3_d2  <= {1'b0, s2_sqx} + {1'b0, s2_sqy};
  end

  // running minimum; strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept && (req.req_type == hgnp_pkg::REQ_QUERY)) begin
      have <= 1'b0;
    end else if (s3_valid && (!have || (s3_d2 < best_d2))) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && (!have || (s3_d2 < best_d2))) begin
      best_d2  <= s3_d2;
      best_idx <= s3_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      rsp_found <= have;
      rsp_index <= have ? hgnp_pkg::IDX_W'(best_idx) : '0;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pipe_busy)
    else $error("pipeline busy while idle");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !pipe_busy)
    else $error("result taken before pipeline drained");

  a_best_scanned: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && have) |-> (CW'(best_idx) < issue_cnt))
    else $error("best index not yet issued");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= point_count))
    else $error("scan ran past fill count");

endmodule
